// ----- src/vtg_pkg.sv -----
`timescale 1ns / 1ps
// Package for the voice transmit gate: field widths, timing constants,
// configuration register indexes and reset values. Depends on nothing.
package vtg_pkg;

    // Field widths of the stream payloads.
    localparam int LEVEL_W   = 13;
    localparam int FRAMES_W  = 5;
    localparam int PREROLL_W = 3;
    localparam int SEQ_W     = 32;
    localparam int HANG_W    = 6;
    localparam int TAIL_W    = 4;

    // Packed payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    // Gate timing and frame limits.
    localparam logic [HANG_W-1:0]    HANGOVER_TICKS = 6'd45;
    localparam logic [TAIL_W-1:0]    PTT_TAIL_TICKS = 4'd12;
    localparam logic [PREROLL_W-1:0] PREROLL_FRAMES = 3'd6;
    localparam logic [FRAMES_W-1:0]  MAX_CAPTURED   = 5'd25;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_VAD_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_TO_TALK_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPORT_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_PRESENT   = 2'd3;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] VAD_THRESHOLD_RESET = 13'd410;

endpackage

// ----- src/voice_transmit_gate.sv -----
`timescale 1ns / 1ps
// Voice transmit gate: voice-activity / push-to-talk gating with hangover,
// pre-roll hold and frame sequence numbering. Depends on vtg_pkg.

// The block takes one tick transaction per clock cycle and returns one result
// transaction for each in the cycle after acceptance. All per-tick work (level
// compare, counter reload or count-down, pre-roll flush and saturation, and the
// 32-bit sequence add) is a short combinational path from the input port and
// the state registers into the state and the result register. The result
// register lets the next tick be accepted while the current result waits, so
// s_tready drops only when a result is held and m_tready is low. Configuration
// writes take effect at the clock edge at which cfg_we is high.
module voice_transmit_gate (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [vtg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vtg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Tick input. tdata, lowest bit up: mic_level[12:0], ptt_pressed[13],
    // muted[14], captured_frames[19:15], zero fill[23:20].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vtg_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result output. tdata, lowest bit up: vad_active[0], flush_preroll[3:1],
    // send_captured[8:4], first_sequence[40:9], preroll_held[43:41],
    // zero fill[47:44].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vtg_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Configuration registers.
    logic [vtg_pkg::LEVEL_W-1:0] vad_threshold_reg;
    logic                        push_to_talk_mode_reg;
    logic                        transport_present_reg;
    logic                        capture_present_reg;

    // Gate state.
    logic [vtg_pkg::HANG_W-1:0]    hangover_count_reg, hangover_count_next;
    logic [vtg_pkg::TAIL_W-1:0]    ptt_tail_count_reg, ptt_tail_count_next;
    logic                          sending_reg, sending_next;
    logic [vtg_pkg::PREROLL_W-1:0] preroll_count_reg, preroll_count_next;
    logic [vtg_pkg::SEQ_W-1:0]     next_sequence_reg, next_sequence_next;

    // Result register.
    logic                           m_tvalid_reg;
    logic                           vad_active_reg, vad_active_next;
    logic [vtg_pkg::PREROLL_W-1:0]  flush_preroll_reg, flush_preroll_next;
    logic [vtg_pkg::FRAMES_W-1:0]   send_captured_reg, send_captured_next;
    logic [vtg_pkg::SEQ_W-1:0]      first_sequence_reg, first_sequence_next;

    // Unpacked input fields.
    logic [vtg_pkg::LEVEL_W-1:0]  in_level;
    logic                         in_ptt;
    logic                         in_muted;
    logic [vtg_pkg::FRAMES_W-1:0] in_frames;

    // Intermediate values.
    logic                         accept;
    logic [vtg_pkg::LEVEL_W-1:0]  level_eff;
    logic [vtg_pkg::FRAMES_W-1:0] frames_eff;
    logic                         speech;
    logic                         gate;
    logic [vtg_pkg::HANG_W-1:0]   send_total;
    logic [vtg_pkg::HANG_W-1:0]   held_sum;

    assign in_level  = s_tdata[12:0];
    assign in_ptt    = s_tdata[13];
    assign in_muted  = s_tdata[14];
    assign in_frames = s_tdata[19:15];

    // Accept a new tick whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vad_threshold_reg     <= vtg_pkg::VAD_THRESHOLD_RESET;
            push_to_talk_mode_reg <= 1'b0;
            transport_present_reg <= 1'b1;
            capture_present_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vtg_pkg::REG_VAD_THRESHOLD:     vad_threshold_reg     <= cfg_wdata;
                vtg_pkg::REG_PUSH_TO_TALK_MODE: push_to_talk_mode_reg <= cfg_wdata[0];
                vtg_pkg::REG_TRANSPORT_PRESENT: transport_present_reg <= cfg_wdata[0];
                vtg_pkg::REG_CAPTURE_PRESENT:   capture_present_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Without a capture device the level and frame count read as zero; excess
    // frames are limited to the drain size.
    always_comb begin
        level_eff  = capture_present_reg ? in_level : '0;
        frames_eff = '0;
        if (capture_present_reg) begin
            frames_eff = (in_frames > vtg_pkg::MAX_CAPTURED) ? vtg_pkg::MAX_CAPTURED
                                                             : in_frames;
        end
    end

    // Gate decision, frame accounting and the next state for one tick.
    always_comb begin
        hangover_count_next = hangover_count_reg;
        ptt_tail_count_next = ptt_tail_count_reg;
        sending_next        = sending_reg;
        preroll_count_next  = preroll_count_reg;
        next_sequence_next  = next_sequence_reg;
        vad_active_next     = 1'b0;
        flush_preroll_next  = '0;
        send_captured_next  = '0;
        first_sequence_next = '0;
        speech              = level_eff >= vad_threshold_reg;
        gate                = 1'b0;
        send_total          = '0;
        held_sum            = '0;

        if (in_muted) begin
            hangover_count_next = '0;
            ptt_tail_count_next = '0;
            sending_next        = 1'b0;
            preroll_count_next  = '0;
        end else begin
            // Counter reload or count-down for the selected mode.
            if (push_to_talk_mode_reg) begin
                if (in_ptt) begin
                    ptt_tail_count_next = vtg_pkg::PTT_TAIL_TICKS;
                end else if (ptt_tail_count_reg != '0) begin
                    ptt_tail_count_next = ptt_tail_count_reg - 1'b1;
                end
                hangover_count_next = '0;
                gate = in_ptt || (ptt_tail_count_next != '0);
            end else begin
                if (speech) begin
                    hangover_count_next = vtg_pkg::HANGOVER_TICKS;
                end else if (hangover_count_reg != '0) begin
                    hangover_count_next = hangover_count_reg - 1'b1;
                end
                ptt_tail_count_next = '0;
                gate = speech || (hangover_count_next != '0);
            end

            // Send path: flush the hold on opening, then number all frames.
            if (gate && transport_present_reg) begin
                if (!sending_reg) begin
                    flush_preroll_next = preroll_count_reg;
                    preroll_count_next = '0;
                end
                send_captured_next = frames_eff;
                send_total = {3'b000, flush_preroll_next} + {1'b0, frames_eff};
                if (send_total != '0) begin
                    first_sequence_next = next_sequence_reg;
                end
                next_sequence_next = next_sequence_reg + {26'd0, send_total};
                sending_next       = 1'b1;
            end else if (capture_present_reg) begin
                // Hold path: keep only the newest pre-roll frames.
                held_sum     = {3'b000, preroll_count_reg} + {1'b0, frames_eff};
                sending_next = 1'b0;
                if (held_sum > {3'b000, vtg_pkg::PREROLL_FRAMES}) begin
                    preroll_count_next = vtg_pkg::PREROLL_FRAMES;
                end else begin
                    preroll_count_next = held_sum[2:0];
                end
            end
            vad_active_next = gate;
        end
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hangover_count_reg <= '0;
            ptt_tail_count_reg <= '0;
            sending_reg        <= 1'b0;
            preroll_count_reg  <= '0;
            next_sequence_reg  <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                hangover_count_reg <= hangover_count_next;
                ptt_tail_count_reg <= ptt_tail_count_next;
                sending_reg        <= sending_next;
                preroll_count_reg  <= preroll_count_next;
                next_sequence_reg  <= next_sequence_next;
                m_tvalid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg       <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            vad_active_reg     <= vad_active_next;
            flush_preroll_reg  <= flush_preroll_next;
            send_captured_reg  <= send_captured_next;
            first_sequence_reg <= first_sequence_next;
        end
    end

    // Result packing; the held count is the current pre-roll state.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, preroll_count_reg, first_sequence_reg,
                       send_captured_reg, flush_preroll_reg, vad_active_reg};

    // The pre-roll hold never exceeds its limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        preroll_count_reg <= vtg_pkg::PREROLL_FRAMES)
        else $error("pre-roll count above limit");

    // Flushed frames only appear while the gate is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (flush_preroll_reg != '0) |-> vad_active_reg)
        else $error("pre-roll flushed with gate closed");

    // A muted tick leaves counters and hold cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_muted |=> (preroll_count_reg == '0) && (hangover_count_reg == '0)
                               && (ptt_tail_count_reg == '0) && !sending_reg)
        else $error("mute did not clear gate state");

    // The sequence advances by exactly the frames reported as sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> next_sequence_reg == $past(next_sequence_reg)
                   + {29'd0, flush_preroll_reg} + {27'd0, send_captured_reg})
        else $error("sequence number out of step with sent frames");

    // Counters of the unused mode stay cleared after a tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !in_muted |=> (hangover_count_reg == '0) || (ptt_tail_count_reg == '0))
        else $error("both gate counters running");

endmodule

// ----- bench/voice_transmit_gate_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for voice_transmit_gate: directed ticks, back-pressure
// and random talk/silence traffic under several configurations, checked against
// an in-bench predictor of the gate. Depends on vtg_pkg and voice_transmit_gate.
module voice_transmit_gate_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam int RING_DEPTH  = 256;

    // One tick as offered on the input stream.
    typedef struct {
        logic [vtg_pkg::LEVEL_W-1:0]  level;
        logic                         ptt;
        logic                         mute;
        logic [vtg_pkg::FRAMES_W-1:0] frames;
    } tick_t;

    // One result as carried on the output stream.
    typedef struct packed {
        logic                          active;
        logic [vtg_pkg::PREROLL_W-1:0] flush;
        logic [vtg_pkg::FRAMES_W-1:0]  sent;
        logic [vtg_pkg::SEQ_W-1:0]     first;
        logic [vtg_pkg::PREROLL_W-1:0] held;
    } gate_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [vtg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vtg_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [vtg_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [vtg_pkg::M_TDATA_W-1:0]  m_tdata;

    // Predictor copy of the configuration and the gate state.
    logic [vtg_pkg::LEVEL_W-1:0]   cfg_threshold;
    logic                          cfg_ptt_mode;
    logic                          cfg_transport;
    logic                          cfg_capture;
    logic [vtg_pkg::HANG_W-1:0]    hang_left;
    logic [vtg_pkg::TAIL_W-1:0]    tail_left;
    logic                          gate_sending;
    logic [vtg_pkg::PREROLL_W-1:0] preroll_frames_held;
    logic [vtg_pkg::SEQ_W-1:0]     next_frame_seq;

    // Predicted results waiting for their transaction, oldest at pred_rd.
    gate_result_t pred_ring [RING_DEPTH];
    int           pred_wr;
    int           pred_rd;
    int           fail_count;
    bit           src_gaps_on;
    bit           sink_gaps_on;
    int           stall_request;

    voice_transmit_gate DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard limit on the run length.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("end of test: mismatches");
        $finish;
    end

    // Appends one predicted result behind the ones still outstanding.
    task automatic store_prediction(input gate_result_t r);
        pred_ring[pred_wr % RING_DEPTH] = r;
        pred_wr++;
    endtask

    // Works out the result of one accepted tick and advances the predicted state.
    task automatic predict_gate_tick(input tick_t t);
        gate_result_t r;
        logic [vtg_pkg::LEVEL_W-1:0] lvl;
        int frames;
        int held_sum;
        logic speech;
        r = '0;
        lvl = t.level;
        frames = t.frames;
        // Mute drops the gate and the hold but keeps the sequence counter.
        if (t.mute) begin
            hang_left = '0;
            tail_left = '0;
            gate_sending = 1'b0;
            preroll_frames_held = '0;
            store_prediction(r);
            return;
        end
        if (!cfg_capture) begin
            lvl = '0;
            frames = 0;
        end
        if (frames > vtg_pkg::MAX_CAPTURED) frames = int'(vtg_pkg::MAX_CAPTURED);
        // Only the counter of the selected mode runs; the other one is cleared.
        if (cfg_ptt_mode) begin
            if (t.ptt) tail_left = vtg_pkg::PTT_TAIL_TICKS;
            else if (tail_left != 0) tail_left = tail_left - 1'b1;
            hang_left = '0;
            r.active = t.ptt || (tail_left != 0);
        end else begin
            speech = (lvl >= cfg_threshold);
            if (speech) hang_left = vtg_pkg::HANGOVER_TICKS;
            else if (hang_left != 0) hang_left = hang_left - 1'b1;
            tail_left = '0;
            r.active = speech || (hang_left != 0);
        end
        // Open gate sends the hold (on the opening tick only), then new frames.
        if (r.active && cfg_transport) begin
            if (!gate_sending) begin
                r.flush = preroll_frames_held;
                preroll_frames_held = '0;
            end
            r.sent = frames[vtg_pkg::FRAMES_W-1:0];
            if (int'(r.flush) + int'(r.sent) != 0) r.first = next_frame_seq;
            next_frame_seq = next_frame_seq + r.flush + r.sent;
            gate_sending = 1'b1;
        end else if (cfg_capture) begin
            held_sum = int'(preroll_frames_held) + frames;
            gate_sending = 1'b0;
            if (held_sum > vtg_pkg::PREROLL_FRAMES) held_sum = int'(vtg_pkg::PREROLL_FRAMES);
            preroll_frames_held = held_sum[vtg_pkg::PREROLL_W-1:0];
        end
        r.held = preroll_frames_held;
        store_prediction(r);
    endtask

    // Offers one tick, waits for its transaction and records the prediction.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{(vtg_pkg::S_TDATA_W - vtg_pkg::LEVEL_W - vtg_pkg::FRAMES_W - 2){1'b0}},
                   t.frames, t.mute, t.ptt, t.level};
        do @(posedge aclk); while (!s_tready);
        predict_gate_tick(t);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pred_wr != pred_rd) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [vtg_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[vtg_pkg::CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            vtg_pkg::REG_VAD_THRESHOLD:     cfg_threshold = value[vtg_pkg::LEVEL_W-1:0];
            vtg_pkg::REG_PUSH_TO_TALK_MODE: cfg_ptt_mode = value[0];
            vtg_pkg::REG_TRANSPORT_PRESENT: cfg_transport = value[0];
            vtg_pkg::REG_CAPTURE_PRESENT:   cfg_capture = value[0];
            default: ;
        endcase
    endtask

    function automatic tick_t make_tick(input int level, input bit ptt, input bit mute,
                                        input int frames);
        tick_t t;
        t.level = level[vtg_pkg::LEVEL_W-1:0];
        t.ptt = ptt;
        t.mute = mute;
        t.frames = frames[vtg_pkg::FRAMES_W-1:0];
        return t;
    endfunction

    // A tick from a talk or a silence stretch, with some noise mixed in.
    function automatic tick_t random_tick(input bit talk);
        tick_t t;
        if (talk || cfg_threshold == 0)
            t.level = 13'($urandom_range(cfg_threshold, 4096));
        else
            t.level = 13'($urandom_range(0, cfg_threshold - 1));
        if ($urandom_range(0, 7) == 0) t.level = 13'($urandom_range(0, 4096));
        t.ptt = cfg_ptt_mode ? talk : 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0) t.ptt = ~t.ptt;
        t.mute = ($urandom_range(0, 49) == 0);
        t.frames = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 4));
        return t;
    endfunction

    // Alternating talk and silence stretches; some silences are long enough to close the gate.
    task automatic run_talk_traffic(input int n_ticks);
        int left;
        int seg_len;
        bit talk;
        left = n_ticks;
        while (left > 0) begin
            talk = ($urandom_range(0, 2) == 0);
            seg_len = talk ? $urandom_range(1, 10) : $urandom_range(1, 60);
            while (seg_len > 0 && left > 0) begin
                send_tick(random_tick(talk));
                seg_len--;
                left--;
            end
        end
    endtask

    // Hand-picked ticks: hold fill and saturation, flush on opening, frame clamp,
    // mute, push-to-talk, missing transport, missing capture and zero threshold.
    task automatic test_directed_cases();
        send_tick(make_tick(0, 0, 0, 3));
        send_tick(make_tick(409, 0, 0, 5));
        send_tick(make_tick(410, 0, 0, 2));
        send_tick(make_tick(4096, 1, 0, 31));
        send_tick(make_tick(0, 0, 0, 0));
        send_tick(make_tick(8191 - 4096, 1, 1, 7));
        send_tick(make_tick(4096, 0, 0, 25));
        wait_drained();
        write_reg(vtg_pkg::REG_PUSH_TO_TALK_MODE, 1);
        send_tick(make_tick(4096, 0, 0, 4));
        send_tick(make_tick(0, 1, 0, 1));
        send_tick(make_tick(0, 0, 0, 0));
        wait_drained();
        write_reg(vtg_pkg::REG_TRANSPORT_PRESENT, 0);
        send_tick(make_tick(0, 1, 0, 9));
        wait_drained();
        write_reg(vtg_pkg::REG_TRANSPORT_PRESENT, 1);
        write_reg(vtg_pkg::REG_CAPTURE_PRESENT, 0);
        send_tick(make_tick(0, 1, 0, 9));
        wait_drained();
        write_reg(vtg_pkg::REG_PUSH_TO_TALK_MODE, 0);
        write_reg(vtg_pkg::REG_VAD_THRESHOLD, 0);
        send_tick(make_tick(0, 0, 0, 5));
        wait_drained();
        write_reg(vtg_pkg::REG_CAPTURE_PRESENT, 1);
        send_tick(make_tick(0, 0, 0, 3));
        send_tick(make_tick(0, 0, 1, 0));
        wait_drained();
    endtask

    // Receiver holds off for a long time while the sender keeps offering, then
    // the sender pauses until everything is back before going on.
    task automatic test_stall_and_drain();
        src_gaps_on = 1'b0;
        stall_request = 250;
        repeat (40) send_tick(random_tick($urandom_range(0, 1)));
        wait_drained();
        src_gaps_on = 1'b1;
        run_talk_traffic(20);
        wait_drained();
    endtask

    task automatic test_config_phase(input int threshold, input bit ptt_mode,
                                     input bit transport, input bit capture,
                                     input int n_ticks);
        wait_drained();
        write_reg(vtg_pkg::REG_VAD_THRESHOLD, threshold);
        write_reg(vtg_pkg::REG_PUSH_TO_TALK_MODE, ptt_mode);
        write_reg(vtg_pkg::REG_TRANSPORT_PRESENT, transport);
        write_reg(vtg_pkg::REG_CAPTURE_PRESENT, capture);
        run_talk_traffic(n_ticks);
    endtask

    // Receiver: random stall bursts, plus long hold-offs on request.
    initial begin : sink
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request > 0) begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (sink_gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                stall_left = $urandom_range(0, 18);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge aclk) begin
        gate_result_t want;
        gate_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.active = m_tdata[0];
            got.flush  = m_tdata[3:1];
            got.sent   = m_tdata[8:4];
            got.first  = m_tdata[40:9];
            got.held   = m_tdata[43:41];
            if (pred_wr == pred_rd) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result transaction at %0t", $realtime);
            end else begin
                want = pred_ring[pred_rd % RING_DEPTH];
                pred_rd++;
                if (got != want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"result mismatch at %0t: expected active=%0d flush=%0d ",
                                  "sent=%0d first=%0d held=%0d, got active=%0d flush=%0d ",
                                  "sent=%0d first=%0d held=%0d"}, $realtime,
                                 want.active, want.flush, want.sent, want.first, want.held,
                                 got.active, got.flush, got.sent, got.first, got.held);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        fail_count = 0;
        pred_wr = 0;
        pred_rd = 0;
        stall_request = 0;
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        cfg_threshold = vtg_pkg::VAD_THRESHOLD_RESET;
        cfg_ptt_mode = 1'b0;
        cfg_transport = 1'b1;
        cfg_capture = 1'b1;
        hang_left = '0;
        tail_left = '0;
        gate_sending = 1'b0;
        preroll_frames_held = '0;
        next_frame_seq = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_stall_and_drain();
        test_config_phase(410, 0, 1, 1, 300);
        test_config_phase(0, 0, 1, 1, 150);
        test_config_phase(4096, 0, 1, 1, 150);
        test_config_phase($urandom_range(1, 4095), 0, 1, 1, 200);
        test_config_phase(410, 1, 1, 1, 300);
        test_config_phase(410, 0, 0, 1, 120);
        test_config_phase(1000, 1, 0, 1, 100);
        test_config_phase(410, 0, 1, 0, 100);
        test_config_phase(2000, 1, 1, 1, 150);
        // Closing stretch at full rate on both sides.
        wait_drained();
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        test_config_phase(410, 0, 1, 1, 200);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pred_wr == pred_rd) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
